// ===== sv/wcc_pkg.sv =====
// ----------------------------------------------------------------------------
// wcc_pkg
// Shared types and constants of the weighted color cast correction pipeline.
// ----------------------------------------------------------------------------
package wcc_pkg;

	localparam int CHANNEL_BITS    = 8;
	localparam int NUM_CHANNELS    = 3;
	localparam int Q_BITS          = 16;
	localparam int DIV_STAGES      = 4;
	localparam int STEPS_PER_STAGE = Q_BITS / DIV_STAGES;
	localparam int NUM_STAGES      = DIV_STAGES + 4;
	localparam int W_BITS          = Q_BITS + 1;
	localparam int C_BITS          = CHANNEL_BITS + 1;
	localparam int PROD_BITS       = C_BITS + W_BITS + 1;
	localparam int V_BITS          = CHANNEL_BITS + Q_BITS + 4;
	localparam int CFG_INDEX_BITS  = 3;

	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [W_BITS-1:0]       weight_t;
	typedef logic [Q_BITS-1:0]       quo_t;
	typedef logic [NUM_STAGES-1:0]   stage_en_t;

	localparam chan_t   CHAN_MAX = chan_t'((1 << CHANNEL_BITS) - 1);
	localparam weight_t W_ONE    = weight_t'(1 << Q_BITS);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SAMPLE_BLUE  = 3'd0,
		REG_SAMPLE_GREEN = 3'd1,
		REG_SAMPLE_RED   = 3'd2,
		REG_TARGET_BLUE  = 3'd3,
		REG_TARGET_GREEN = 3'd4,
		REG_TARGET_RED   = 3'd5
	} reg_index_t;

	// per-channel context carried along the divider stages
	typedef struct packed {
		chan_t             pix;
		chan_t             den;
		logic              eq;
		logic              full;
		logic signed [C_BITS-1:0] corr;
	} chan_ctx_t;

endpackage

// ===== sv/wcc_if.sv =====
// ----------------------------------------------------------------------------
// wcc interfaces
// Pixel input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface wcc_pix_in_if
	import wcc_pkg::*;
	();
	logic  valid;
	logic  ready;
	chan_t blue_in;
	chan_t green_in;
	chan_t red_in;

	modport source (output valid, blue_in, green_in, red_in, input ready);
	modport sink   (input valid, blue_in, green_in, red_in, output ready);
endinterface

interface wcc_pix_out_if
	import wcc_pkg::*;
	();
	logic  valid;
	logic  ready;
	chan_t blue_out;
	chan_t green_out;
	chan_t red_out;

	modport source (output valid, blue_out, green_out, red_out, input ready);
	modport sink   (input valid, blue_out, green_out, red_out, output ready);
endinterface

interface wcc_cfg_if
	import wcc_pkg::*;
	();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	chan_t                     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/weighted_color_cast_correction.sv =====
// ----------------------------------------------------------------------------
// weighted_color_cast_correction
// Pulls each BGR channel toward its target level with a weight that falls
// off linearly away from the reference white sample.
// ----------------------------------------------------------------------------
// path: distance, divider, weight, product and saturation stages to output
// throughput: one pixel per cycle unless pix_out.ready stalls; the 16-bit
//   quotient is split over four divider stages of four bits each
// reset: pipeline valid bits clear, all sample and target levels go to 255
// ----------------------------------------------------------------------------
module weighted_color_cast_correction
	import wcc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	wcc_pix_in_if.sink    pix_in,
	wcc_pix_out_if.source pix_out,
	wcc_cfg_if.sink       cfg
);

	chan_t     sample_q [NUM_CHANNELS];
	chan_t     target_q [NUM_CHANNELS];
	stage_en_t vld_q;
	stage_en_t en;
	chan_t     pix_in_ch  [NUM_CHANNELS];
	chan_t     pix_out_ch [NUM_CHANNELS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				sample_q[i] <= CHAN_MAX;
				target_q[i] <= CHAN_MAX;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SAMPLE_BLUE:  sample_q[0] <= cfg.data;
				REG_SAMPLE_GREEN: sample_q[1] <= cfg.data;
				REG_SAMPLE_RED:   sample_q[2] <= cfg.data;
				REG_TARGET_BLUE:  target_q[0] <= cfg.data;
				REG_TARGET_GREEN: target_q[1] <= cfg.data;
				REG_TARGET_RED:   target_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// a stage loads when empty or when its contents move on
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || pix_out.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= pix_in.valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign pix_in.ready = en[0];

	assign pix_in_ch[0] = pix_in.blue_in;
	assign pix_in_ch[1] = pix_in.green_in;
	assign pix_in_ch[2] = pix_in.red_in;

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
		wcc_channel u_chan (
			.clk    (clk),
			.en     (en),
			.pix    (pix_in_ch[i]),
			.sample (sample_q[i]),
			.target (target_q[i]),
			.result (pix_out_ch[i])
		);
	end

	assign pix_out.valid     = vld_q[NUM_STAGES-1];
	assign pix_out.blue_out  = pix_out_ch[0];
	assign pix_out.green_out = pix_out_ch[1];
	assign pix_out.red_out   = pix_out_ch[2];

endmodule

// ===== sv/wcc_channel.sv =====
// ----------------------------------------------------------------------------
// wcc_channel
// One color channel: weight by pipelined restoring division, scaled
// correction, truncation and saturation.
// ----------------------------------------------------------------------------
module wcc_channel
	import wcc_pkg::*;
(
	input  logic      clk,
	input  stage_en_t en,
	input  chan_t     pix,
	input  chan_t     sample,
	input  chan_t     target,
	output chan_t     result
);

	chan_ctx_t ctx_s1;
	chan_t     rem_s1;

	chan_ctx_t ctx_div_s [DIV_STAGES];
	chan_t     rem_div_s [DIV_STAGES];
	quo_t      quo_div_s [DIV_STAGES];

	chan_ctx_t ctx_src [DIV_STAGES+1];
	chan_t     rem_src [DIV_STAGES+1];
	quo_t      quo_src [DIV_STAGES+1];

	chan_t                       pix_s6;
	logic signed [C_BITS-1:0]    corr_s6;
	weight_t                     w_s6;
	chan_t                       pix_s7;
	logic signed [PROD_BITS-1:0] prod_s7;
	chan_t                       out_s8;

	// stage 1: distance to sample and divisor
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ctx_s1.pix  <= pix;
			ctx_s1.eq   <= (pix == sample);
			ctx_s1.corr <= signed'({1'b0, sample}) - signed'({1'b0, target});
			if (pix < sample) begin
				rem_s1      <= sample - pix;
				ctx_s1.den  <= sample;
				ctx_s1.full <= (pix == '0);
			end else begin
				rem_s1      <= pix - sample;
				ctx_s1.den  <= CHAN_MAX - sample;
				ctx_s1.full <= (pix == CHAN_MAX);
			end
		end
	end

	assign ctx_src[0] = ctx_s1;
	assign rem_src[0] = rem_s1;
	assign quo_src[0] = '0;

	// stages 2..5: quotient bits of distance * 2^16 / divisor
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		chan_t rem_nxt;
		quo_t  quo_nxt;

		always_comb begin
			logic [CHANNEL_BITS:0] dbl;
			chan_t                 r;
			quo_t                  q;
			r = rem_src[j];
			q = quo_src[j];
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				dbl = {r, 1'b0};
				if (dbl >= {1'b0, ctx_src[j].den}) begin
					r = chan_t'(dbl - {1'b0, ctx_src[j].den});
					q = {q[Q_BITS-2:0], 1'b1};
				end else begin
					r = dbl[CHANNEL_BITS-1:0];
					q = {q[Q_BITS-2:0], 1'b0};
				end
			end
			rem_nxt = r;
			quo_nxt = q;
		end

		always_ff @(posedge clk) begin
			if (en[1+j]) begin
				ctx_div_s[j] <= ctx_src[j];
				rem_div_s[j] <= rem_nxt;
				quo_div_s[j] <= quo_nxt;
			end
		end

		assign ctx_src[j+1] = ctx_div_s[j];
		assign rem_src[j+1] = rem_div_s[j];
		assign quo_src[j+1] = quo_div_s[j];
	end

	// stage 6: weight in q1.16
	always_ff @(posedge clk) begin
		if (en[DIV_STAGES+1]) begin
			pix_s6  <= ctx_src[DIV_STAGES].pix;
			corr_s6 <= ctx_src[DIV_STAGES].corr;
			if (ctx_src[DIV_STAGES].eq) begin
				w_s6 <= W_ONE;
			end else if (ctx_src[DIV_STAGES].full) begin
				w_s6 <= '0;
			end else begin
				w_s6 <= W_ONE - {1'b0, quo_src[DIV_STAGES]};
			end
		end
	end

	// stage 7: correction times weight
	always_ff @(posedge clk) begin
		if (en[DIV_STAGES+2]) begin
			pix_s7  <= pix_s6;
			prod_s7 <= PROD_BITS'(corr_s6) * PROD_BITS'(signed'({1'b0, w_s6}));
		end
	end

	// stage 8: subtract, truncate, saturate
	logic signed [V_BITS-1:0] v;

	assign v = signed'({{(V_BITS-CHANNEL_BITS-Q_BITS){1'b0}}, pix_s7, {Q_BITS{1'b0}}})
		- V_BITS'(prod_s7);

	always_ff @(posedge clk) begin
		if (en[DIV_STAGES+3]) begin
			if (v <= 0) begin
				out_s8 <= '0;
			end else if (|v[V_BITS-1:CHANNEL_BITS+Q_BITS]) begin
				out_s8 <= CHAN_MAX;
			end else begin
				out_s8 <= v[Q_BITS +: CHANNEL_BITS];
			end
		end
	end

	assign result = out_s8;

endmodule
